// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is switched off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Concurrent check that also runs during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/hsv_pkg.sv
package hsv_pkg;

    // Hue scale: degrees times 64, one sector is 60 degrees.
    localparam logic [14:0] HUE_FULL   = 15'd23040;
    localparam logic [11:0] HUE_SECTOR = 12'd3840;
    localparam logic [14:0] HUE_B1     = 15'd3840;
    localparam logic [14:0] HUE_B2     = 15'd7680;
    localparam logic [14:0] HUE_B3     = 15'd11520;
    localparam logic [14:0] HUE_B4     = 15'd15360;
    localparam logic [14:0] HUE_B5     = 15'd19200;

    // Divisor of the q and t levels (255 * 3840), its half for rounding,
    // and a reciprocal scaled by 2^QT_SHIFT, rounded down.
    localparam logic [19:0] DEN_QT   = 20'd979200;
    localparam logic [27:0] QT_HALF  = 28'd489600;
    localparam logic [18:0] QT_RECIP = 19'd280716;
    localparam int          QT_SHIFT = 38;

    // Divisor of the p level and its rounding offset.
    localparam logic [7:0]  DEN_P    = 8'd255;
    localparam logic [15:0] P_HALF   = 16'd127;

    typedef enum logic [2:0] {
        SEC_0 = 3'd0,
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5
    } t_sector;

    // Load enables for the three stages of a level divider.
    typedef struct packed {
        logic en_a;
        logic en_b;
        logic en_c;
    } t_div_ctl;

endpackage

// File: rtl/hsv_qt_div.sv
module hsv_qt_div (
    input  logic              i_clk,
    input  hsv_pkg::t_div_ctl i_ctl,
    input  logic [7:0]        i_brightness,
    input  logic [19:0]       i_prod,
    output logic [7:0]        o_level
);
    import hsv_pkg::*;

    // Computes round(v * (DEN_QT - prod) / DEN_QT) with ties rounded up.
    logic [27:0] r_num;
    logic [27:0] n_num;
    logic [27:0] r_num_b;
    logic [8:0]  r_est;
    logic [46:0] w_scaled;
    logic [8:0]  n_est;
    logic [28:0] w_rem;
    logic [7:0]  r_level;
    logic [7:0]  n_level;

    assign n_num = ({20'd0, i_brightness} * {8'd0, DEN_QT - i_prod}) + QT_HALF;

    // The reciprocal estimate is the true quotient or one below it.
    assign w_scaled = {19'd0, r_num} * {28'd0, QT_RECIP};
    assign n_est    = w_scaled[46:QT_SHIFT];

    assign w_rem   = {1'b0, r_num_b} - ({20'd0, r_est} * {9'd0, DEN_QT});
    assign n_level = (w_rem >= {9'd0, DEN_QT}) ? 8'(r_est + 9'd1) : r_est[7:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_a) begin
            r_num <= n_num;
        end
        if (i_ctl.en_b) begin
            r_num_b <= r_num;
            r_est   <= n_est;
        end
        if (i_ctl.en_c) begin
            r_level <= n_level;
        end
    end

    assign o_level = r_level;

endmodule

// File: rtl/hsv_to_rgb_converter_unit.sv
// HSV to RGB pixel converter.
// The input stream carries one pixel per transaction: hue in degrees times 64,
// saturation and value as fractions of 255. The output stream carries one
// transaction per input transaction with the red, green and blue channels,
// rounded to nearest, in the same order as the input.
// The datapath is a five-stage pipeline: sector split, products, the p estimate
// with the first divider stage, the p correction with the reciprocal estimates,
// and the q and t corrections. One pixel is accepted in every cycle while the
// receiver keeps up.
// Every stage has its own valid bit and loads whenever it is empty or the stage
// after it moves, so a stalled receiver only holds the last stage and bubbles
// ahead of it are filled; the input side keeps accepting until all five
// stages are full. Nothing is dropped or repeated under a stall.
// A synchronous active-low reset clears all valid bits, so the output stream
// is idle after reset; the data registers are not reset.
module hsv_to_rgb_converter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // hue[14:0], saturation[22:15], brightness[30:23]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // red[7:0], green[15:8], blue[23:16]
);
    import hsv_pkg::*;

    // Stage valid bits and per-stage load enables.
    logic [4:0] r_vld;
    logic [4:0] w_rdy;

    assign w_rdy[4] = !r_vld[4] || m_axis_tready;
    assign w_rdy[3] = !r_vld[3] || w_rdy[4];
    assign w_rdy[2] = !r_vld[2] || w_rdy[3];
    assign w_rdy[1] = !r_vld[1] || w_rdy[2];
    assign w_rdy[0] = !r_vld[0] || w_rdy[1];

    assign s_axis_tready = w_rdy[0];
    assign m_axis_tvalid = r_vld[4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 5'd0;
        end else begin
            if (w_rdy[0]) r_vld[0] <= s_axis_tvalid;
            if (w_rdy[1]) r_vld[1] <= r_vld[0];
            if (w_rdy[2]) r_vld[2] <= r_vld[1];
            if (w_rdy[3]) r_vld[3] <= r_vld[2];
            if (w_rdy[4]) r_vld[4] <= r_vld[3];
        end
    end

    // Stage 1: set hues of a full turn or more to zero, then split the hue
    // into its sector and the offset within that sector.
    logic [14:0] w_hue;
    logic [7:0]  w_sat;
    logic [7:0]  w_val;
    logic [14:0] w_hue_c;
    logic [14:0] w_base;
    t_sector     n1_sec;
    t_sector     r1_sec;
    logic [11:0] r1_fr;
    logic [7:0]  r1_sat;
    logic [7:0]  r1_val;

    assign w_hue   = s_axis_tdata[14:0];
    assign w_sat   = s_axis_tdata[22:15];
    assign w_val   = s_axis_tdata[30:23];
    assign w_hue_c = (w_hue >= HUE_FULL) ? 15'd0 : w_hue;

    always_comb begin
        priority if (w_hue_c >= HUE_B5) begin
            n1_sec = SEC_5;
            w_base = HUE_B5;
        end else if (w_hue_c >= HUE_B4) begin
            n1_sec = SEC_4;
            w_base = HUE_B4;
        end else if (w_hue_c >= HUE_B3) begin
            n1_sec = SEC_3;
            w_base = HUE_B3;
        end else if (w_hue_c >= HUE_B2) begin
            n1_sec = SEC_2;
            w_base = HUE_B2;
        end else if (w_hue_c >= HUE_B1) begin
            n1_sec = SEC_1;
            w_base = HUE_B1;
        end else begin
            n1_sec = SEC_0;
            w_base = 15'd0;
        end
    end

    // Stage 2: saturation times the fraction and its complement, and the
    // rounded numerator of the p level.
    t_sector     r2_sec;
    logic [7:0]  r2_val;
    logic [19:0] r2_dq;
    logic [19:0] r2_dt;
    logic [15:0] r2_pn;

    // Stage 3: p estimate through the reciprocal of 255.
    t_sector     r3_sec;
    logic [7:0]  r3_val;
    logic [15:0] r3_pn;
    logic [8:0]  r3_pe;
    logic [24:0] w_p257;

    // Stage 4: p correction.
    t_sector     r4_sec;
    logic [7:0]  r4_val;
    logic [7:0]  r4_p;
    logic [16:0] w_prem;
    logic [7:0]  n4_p;

    // Stage 5: registers feeding the channel routing.
    t_sector     r5_sec;
    logic [7:0]  r5_val;
    logic [7:0]  r5_p;
    logic [7:0]  w_q;
    logic [7:0]  w_t;

    assign w_p257 = {9'd0, r2_pn} * 25'd257;
    assign w_prem = {1'b0, r3_pn} - ({8'd0, r3_pe} * {9'd0, DEN_P});
    assign n4_p   = (w_prem >= {9'd0, DEN_P}) ? 8'(r3_pe + 9'd1) : r3_pe[7:0];

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r1_sec <= n1_sec;
            r1_fr  <= 12'(w_hue_c - w_base);
            r1_sat <= w_sat;
            r1_val <= w_val;
        end
        if (w_rdy[1]) begin
            r2_sec <= r1_sec;
            r2_val <= r1_val;
            r2_dq  <= {12'd0, r1_sat} * {8'd0, r1_fr};
            r2_dt  <= {12'd0, r1_sat} * {8'd0, HUE_SECTOR - r1_fr};
            r2_pn  <= ({8'd0, r1_val} * {8'd0, DEN_P - r1_sat}) + P_HALF;
        end
        if (w_rdy[2]) begin
            r3_sec <= r2_sec;
            r3_val <= r2_val;
            r3_pn  <= r2_pn;
            r3_pe  <= w_p257[24:16];
        end
        if (w_rdy[3]) begin
            r4_sec <= r3_sec;
            r4_val <= r3_val;
            r4_p   <= n4_p;
        end
        if (w_rdy[4]) begin
            r5_sec <= r4_sec;
            r5_val <= r4_val;
            r5_p   <= r4_p;
        end
    end

    // The q and t levels run through their own three-stage dividers,
    // aligned with stages 3 to 5.
    t_div_ctl w_div_ctl;

    assign w_div_ctl.en_a = w_rdy[2];
    assign w_div_ctl.en_b = w_rdy[3];
    assign w_div_ctl.en_c = w_rdy[4];

    hsv_qt_div u_div_q (
        .i_clk        (i_clk),
        .i_ctl        (w_div_ctl),
        .i_brightness (r2_val),
        .i_prod       (r2_dq),
        .o_level      (w_q)
    );

    hsv_qt_div u_div_t (
        .i_clk        (i_clk),
        .i_ctl        (w_div_ctl),
        .i_brightness (r2_val),
        .i_prod       (r2_dt),
        .o_level      (w_t)
    );

    // Route value, p, q and t to the channels by sector. The routing reads
    // only stage 5 registers, so the output holds steady during a stall.
    logic [7:0] w_red;
    logic [7:0] w_green;
    logic [7:0] w_blue;

    always_comb begin
        unique case (r5_sec)
            SEC_0: begin
                w_red = r5_val; w_green = w_t;    w_blue = r5_p;
            end
            SEC_1: begin
                w_red = w_q;    w_green = r5_val; w_blue = r5_p;
            end
            SEC_2: begin
                w_red = r5_p;   w_green = r5_val; w_blue = w_t;
            end
            SEC_3: begin
                w_red = r5_p;   w_green = w_q;    w_blue = r5_val;
            end
            SEC_4: begin
                w_red = w_t;    w_green = r5_p;   w_blue = r5_val;
            end
            default: begin
                w_red = r5_val; w_green = r5_p;   w_blue = w_q;
            end
        endcase
    end

    assign m_axis_tdata = {w_blue, w_green, w_red};

endmodule

// File: rtl/hsv_chk.sv
`include "assert_macros.svh"

module hsv_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // A result is offered but the receiver holds it off.
    logic w_stall;

    assign w_stall = m_axis_tvalid && !m_axis_tready;

    // A result that is not taken stays offered.
    `ASSERT_CLK(a_out_hold, w_stall |=> m_axis_tvalid, "output valid dropped under stall")

    // A result that is not taken keeps its channels.
    `ASSERT_CLK(a_out_stable, w_stall |=> $stable(m_axis_tdata), "output data changed in stall")

    // The input side only blocks when the whole pipeline is full and the output is stalled.
    `ASSERT_CLK(a_in_block, !s_axis_tready |-> w_stall, "input blocked with room to move")

    // Reset empties the pipeline.
    `ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !m_axis_tvalid, "output valid right after reset")

endmodule

bind hsv_to_rgb_converter_unit hsv_chk u_hsv_chk (.*);
